// ----- sv/gcd_pkg.sv -----
package gcd_pkg;

    localparam int ANG_W = 32;
    localparam int CR_W  = 34;
    localparam int VR_W  = 36;
    localparam int SQ_STEPS = 32;

    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [63:0] ONE_Q60         = 64'h1000_0000_0000_0000;

    localparam logic CFG_UNITY_TOL = 1'b0;
    localparam logic CFG_ZERO_TOL  = 1'b1;

    function automatic logic [29:0] atan_at(input logic [5:0] i);
        case (i)
            6'd0:  return 30'd536870912;
            6'd1:  return 30'd316933406;
            6'd2:  return 30'd167458907;
            6'd3:  return 30'd85004756;
            6'd4:  return 30'd42667331;
            6'd5:  return 30'd21354465;
            6'd6:  return 30'd10679838;
            6'd7:  return 30'd5340245;
            6'd8:  return 30'd2670163;
            6'd9:  return 30'd1335087;
            6'd10: return 30'd667544;
            6'd11: return 30'd333772;
            6'd12: return 30'd166886;
            6'd13: return 30'd83443;
            6'd14: return 30'd41722;
            6'd15: return 30'd20861;
            6'd16: return 30'd10430;
            6'd17: return 30'd5215;
            6'd18: return 30'd2608;
            6'd19: return 30'd1304;
            6'd20: return 30'd652;
            6'd21: return 30'd326;
            6'd22: return 30'd163;
            6'd23: return 30'd81;
            6'd24: return 30'd41;
            6'd25: return 30'd20;
            6'd26: return 30'd10;
            6'd27: return 30'd5;
            6'd28: return 30'd3;
            6'd29: return 30'd1;
            6'd30: return 30'd1;
            default: return 30'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

    function automatic logic [31:0] abs_sat(input logic signed [32:0] c);
        logic [32:0] u;
        u = c[32] ? 33'(-c) : 33'(c);
        if (u > {1'b0, HALF_TURN})
            u = {1'b0, HALF_TURN};
        return u[31:0];
    endfunction

endpackage

// ----- sv/gcd_sincos.sv -----
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int STEPS = 30
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [ANG_W-1:0]         angle,
    output logic signed [31:0]       cos_val,
    output logic signed [31:0]       sin_val
);

    logic signed [CR_W-1:0] x_reg [0:STEPS];
    logic signed [CR_W-1:0] y_reg [0:STEPS];
    logic signed [CR_W-1:0] z_reg [0:STEPS];
    logic                   flip_reg [0:STEPS];
    logic signed [31:0]     cos_reg;
    logic signed [31:0]     sin_reg;

    logic [ANG_W-1:0]       ang_plus;
    logic                   flip_next;
    logic [ANG_W-1:0]       ang_next;
    logic signed [CR_W-1:0] cos_next;
    logic signed [CR_W-1:0] sin_next;

    assign ang_plus  = angle + QUARTER_TURN;
    assign flip_next = ang_plus[ANG_W-1];
    assign ang_next  = flip_next ? angle + HALF_TURN : angle;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= {{(CR_W-32){1'b0}}, CORDIC_GAIN_Q30};
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(CR_W-ANG_W){ang_next[ANG_W-1]}}, ang_next};
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CR_W-1:0] xs;
        logic signed [CR_W-1:0] ys;
        logic signed [CR_W-1:0] at;
        logic                   up;
        logic signed [CR_W-1:0] x_next;
        logic signed [CR_W-1:0] y_next;
        logic signed [CR_W-1:0] z_next;

        assign xs     = x_reg[i] >>> i;
        assign ys     = y_reg[i] >>> i;
        assign at     = {{(CR_W-30){1'b0}}, atan_at(6'(i))};
        assign up     = ~z_reg[i][CR_W-1];
        assign x_next = up ? x_reg[i] - ys : x_reg[i] + ys;
        assign y_next = up ? y_reg[i] + xs : y_reg[i] - xs;
        assign z_next = up ? z_reg[i] - at : z_reg[i] + at;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign cos_next = flip_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    assign sin_next = flip_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next[31:0];
            sin_reg <= sin_next[31:0];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ----- sv/gcd_isqrt.sv -----
module gcd_isqrt
    import gcd_pkg::*;
#(
    parameter int TAG_W = 33
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [63:0]      arg,
    input  logic [TAG_W-1:0] tag_in,
    output logic [31:0]      root,
    output logic [TAG_W-1:0] tag_out
);

    logic [63:0]      v_reg   [0:SQ_STEPS-1];
    logic [63:0]      r_reg   [0:SQ_STEPS-1];
    logic [TAG_W-1:0] tag_reg [0:SQ_STEPS-1];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_digit
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]      v_in;
        logic [63:0]      r_in;
        logic [TAG_W-1:0] t_in;
        logic [64:0]      trial;
        logic             take;
        logic [63:0]      v_next;
        logic [63:0]      r_next;

        if (k == 0)
        begin : g_first
            assign v_in = arg;
            assign r_in = '0;
            assign t_in = tag_in;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
            assign t_in = tag_reg[k-1];
        end

        assign trial  = {1'b0, r_in} + {1'b0, BIT};
        assign take   = {1'b0, v_in} >= trial;
        assign v_next = take ? v_in - trial[63:0] : v_in;
        assign r_next = take ? (r_in >> 1) + BIT : r_in >> 1;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]   <= v_next;
                r_reg[k]   <= r_next;
                tag_reg[k] <= t_in;
            end
        end
    end

    assign root    = r_reg[SQ_STEPS-1][31:0];
    assign tag_out = tag_reg[SQ_STEPS-1];

endmodule

// ----- sv/gcd_atan2.sv -----
module gcd_atan2
    import gcd_pkg::*;
#(
    parameter int STEPS = 30,
    parameter int TAG_W = 33
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [31:0]     x_in,
    input  logic [31:0]            y_in,
    input  logic [TAG_W-1:0]       tag_in,
    output logic signed [CR_W-1:0] angle,
    output logic [TAG_W-1:0]       tag_out
);

    logic signed [VR_W-1:0] x_reg [0:STEPS];
    logic signed [VR_W-1:0] y_reg [0:STEPS];
    logic signed [CR_W-1:0] z_reg [0:STEPS];
    logic [TAG_W-1:0]       tag_reg [0:STEPS];

    logic signed [VR_W-1:0] xe;
    logic signed [VR_W-1:0] ye;
    logic signed [VR_W-1:0] x0_next;
    logic signed [VR_W-1:0] y0_next;
    logic signed [CR_W-1:0] z0_next;

    assign xe      = {{(VR_W-32){x_in[31]}}, x_in};
    assign ye      = {{(VR_W-32){1'b0}}, y_in};
    assign x0_next = x_in[31] ? ye : xe;
    assign y0_next = x_in[31] ? -xe : ye;
    assign z0_next = x_in[31] ? {{(CR_W-32){1'b0}}, QUARTER_TURN} : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [VR_W-1:0] xs;
        logic signed [VR_W-1:0] ys;
        logic signed [CR_W-1:0] at;
        logic                   down;
        logic signed [VR_W-1:0] x_next;
        logic signed [VR_W-1:0] y_next;
        logic signed [CR_W-1:0] z_next;

        assign xs     = x_reg[i] >>> i;
        assign ys     = y_reg[i] >>> i;
        assign at     = {{(CR_W-30){1'b0}}, atan_at(6'(i))};
        assign down   = ~y_reg[i][VR_W-1] && (y_reg[i] != '0);
        assign x_next = down ? x_reg[i] + ys : x_reg[i] - ys;
        assign y_next = down ? y_reg[i] - xs : y_reg[i] + xs;
        assign z_next = down ? z_reg[i] + at : z_reg[i] - at;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign angle   = z_reg[STEPS];
    assign tag_out = tag_reg[STEPS];

endmodule

// ----- sv/great_circle_distance_core.sv -----
// Central angle between two sphere points by the spherical law of cosines, with a
// cross-product fallback near zero distance. Fully pipelined: one point pair is taken
// every cycle unless the pipeline is frozen. Each pair passes through the three
// parallel sin/cos CORDIC pipelines, five product stages, a 32-stage square root and
// the atan2 CORDIC pipeline. A stall while a result waits at the output freezes the
// whole pipeline and is passed straight back as in_stall; a stall with no result
// waiting has no effect.
module great_circle_distance_core
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] lng_a,
    input  logic signed [31:0] lat_a,
    input  logic [31:0] lng_b,
    input  logic signed [31:0] lat_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] central_angle,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LAT = 2 * CORDIC_STEPS + 42;

    logic        en;
    logic        in_accept;
    logic [LAT-1:0] vld_reg;
    logic [15:0] unity_tol_reg;
    logic [15:0] zero_tol_reg;

    logic [31:0] dl;
    logic signed [31:0] ca, sa, cb, sb, cd, sd;

    assign en        = ~vld_reg[LAT-1] | ~out_stall;
    assign in_stall  = ~en;
    assign in_accept = in_valid & en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unity_tol_reg <= 16'd1;
            zero_tol_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UNITY_TOL: unity_tol_reg <= cfg_data;
                CFG_ZERO_TOL:  zero_tol_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dl = lng_a - lng_b;

    gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_a
    (
        .clk(clk), .en(en), .angle(lat_a), .cos_val(ca), .sin_val(sa)
    );

    gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_b
    (
        .clk(clk), .en(en), .angle(lat_b), .cos_val(cb), .sin_val(sb)
    );

    gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_d
    (
        .clk(clk), .en(en), .angle(dl), .cos_val(cd), .sin_val(sd)
    );

    logic signed [31:0] sasb_reg, cacb_reg, sacb_reg, x1_reg, y1_reg;
    logic signed [31:0] sb1_reg, cb1_reg, cd1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sasb_reg <= qmul(sa, sb);
            cacb_reg <= qmul(ca, cb);
            sacb_reg <= qmul(sa, cb);
            x1_reg   <= qmul(cd, ca);
            y1_reg   <= qmul(sd, ca);
            sb1_reg  <= sb;
            cb1_reg  <= cb;
            cd1_reg  <= cd;
        end
    end

    logic signed [31:0] fpart_reg, cx2_reg, xsb_reg, sasb2_reg, sacb2_reg;
    logic signed [32:0] cz2_reg;
    logic signed [31:0] y1cb;
    logic signed [32:0] cz2_next;

    assign y1cb     = qmul(y1_reg, cb1_reg);
    assign cz2_next = 33'sd0 - {y1cb[31], y1cb};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fpart_reg <= qmul(cacb_reg, cd1_reg);
            cx2_reg   <= qmul(y1_reg, sb1_reg);
            xsb_reg   <= qmul(x1_reg, sb1_reg);
            cz2_reg   <= cz2_next;
            sasb2_reg <= sasb_reg;
            sacb2_reg <= sacb_reg;
        end
    end

    logic signed [32:0] f_sum;
    logic signed [31:0] f_next;
    logic signed [31:0] f_reg;
    logic signed [32:0] cx3_reg, cy3_reg, cz3_reg;
    logic signed [32:0] cy3_next;

    assign f_sum    = {sasb2_reg[31], sasb2_reg} + {fpart_reg[31], fpart_reg};
    assign f_next   = (f_sum[32] != f_sum[31]) ? (f_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                               : f_sum[31:0];
    assign cy3_next = {sacb2_reg[31], sacb2_reg} - {xsb_reg[31], xsb_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg   <= f_next;
            cx3_reg <= {cx2_reg[31], cx2_reg};
            cy3_reg <= cy3_next;
            cz3_reg <= cz2_reg;
        end
    end

    logic signed [32:0] d_f;
    logic [32:0]        ad_f;
    logic               small_next;
    logic signed [31:0] fc_next;
    logic [30:0]        fa;
    logic [31:0]        ux, uy, uz;
    logic               small4_reg;
    logic signed [31:0] fc4_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [61:0]        fafa_reg;

    assign d_f        = {f_reg[31], f_reg} - 33'sh0_4000_0000;
    assign ad_f       = d_f[32] ? 33'(-d_f) : 33'(d_f);
    assign small_next = ad_f <= {17'd0, unity_tol_reg};
    assign fc_next    = (f_reg > 32'sh4000_0000) ? 32'sh4000_0000 :
                        (f_reg < 32'shC000_0000) ? 32'shC000_0000 : f_reg;
    assign fa         = fc_next[31] ? 31'(-fc_next) : fc_next[30:0];
    assign ux         = abs_sat(cx3_reg);
    assign uy         = abs_sat(cy3_reg);
    assign uz         = abs_sat(cz3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            small4_reg <= small_next;
            fc4_reg    <= fc_next;
            sqx_reg    <= 64'(ux) * 64'(ux);
            sqy_reg    <= 64'(uy) * 64'(uy);
            sqz_reg    <= 64'(uz) * 64'(uz);
            fafa_reg   <= 62'(fa) * 62'(fa);
        end
    end

    logic [63:0]        arg_next;
    logic [63:0]        arg_reg;
    logic               small5_reg;
    logic signed [31:0] fc5_reg;

    assign arg_next = small4_reg ? sqx_reg + sqy_reg + sqz_reg
                                 : ONE_Q60 - {2'b00, fafa_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg    <= arg_next;
            small5_reg <= small4_reg;
            fc5_reg    <= fc4_reg;
        end
    end

    logic [31:0] len;
    logic [32:0] sq_tag;

    gcd_isqrt #(.TAG_W(33)) u_isqrt
    (
        .clk(clk), .en(en), .arg(arg_reg), .tag_in({small5_reg, fc5_reg}),
        .root(len), .tag_out(sq_tag)
    );

    logic [63:0]        conv_prod;
    logic [31:0]        conv_next;
    logic [31:0]        conv_reg;
    logic [31:0]        len_reg;
    logic signed [31:0] fcm_reg;
    logic               smallm_reg;

    assign conv_prod = 64'(len) * 64'(TWO_OVER_PI_Q32);
    assign conv_next = (conv_prod[63:32] > HALF_TURN) ? HALF_TURN : conv_prod[63:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            conv_reg   <= conv_next;
            len_reg    <= len;
            fcm_reg    <= sq_tag[31:0];
            smallm_reg <= sq_tag[32];
        end
    end

    logic signed [CR_W-1:0] z_at;
    logic [32:0]            at_tag;

    gcd_atan2 #(.STEPS(CORDIC_STEPS), .TAG_W(33)) u_atan2
    (
        .clk(clk), .en(en), .x_in(fcm_reg), .y_in(len_reg),
        .tag_in({smallm_reg, conv_reg}), .angle(z_at), .tag_out(at_tag)
    );

    logic [31:0] zc;
    logic [31:0] res;
    logic [31:0] central_angle_next;
    logic [31:0] central_angle_reg;

    assign zc  = z_at[CR_W-1] ? 32'd0 :
                 (z_at > {{(CR_W-32){1'b0}}, HALF_TURN}) ? HALF_TURN : z_at[31:0];
    assign res = at_tag[32] ? at_tag[31:0] : zc;
    assign central_angle_next = (res <= {16'd0, zero_tol_reg}) ? 32'd0 : res;

    always_ff @(posedge clk)
    begin
        if (en)
            central_angle_reg <= central_angle_next;
    end

    assign central_angle = central_angle_reg;

endmodule

// ----- sv/gcd_checker.sv -----
module gcd_checker
    import gcd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] central_angle
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(central_angle))
        else $error("stalled result beat changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> central_angle <= HALF_TURN)
        else $error("central angle beyond half turn");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while pipeline frozen");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (.*);

// ----- bench/tb.sv -----
module tb;
    import gcd_pkg::*;

    localparam int STEPS      = 30;
    localparam int LATENCY    = 2 * STEPS + 42;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 240;

    localparam longint ARC_TAB [0:30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1
    };

    class angle_board;
        logic [31:0] pending_angles[$];
        logic [15:0] unity_tol;
        logic [15:0] zero_tol;
        int errors;

        function new();
            unity_tol = 16'd1;
            zero_tol  = 16'd1;
            errors    = 0;
        endfunction

        function longint qm(input longint a, input longint b);
            longint p;
            p = a * b;
            return p >>> 30;
        endfunction

        function logic [63:0] root64(input logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - r - b;
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [63:0] sq_sat(input longint c);
            logic [63:0] u;
            u = (c < 0) ? 64'(-c) : 64'(c);
            if (u > 64'h8000_0000)
                u = 64'h8000_0000;
            return u * u;
        endfunction

        function void rotate(input logic [31:0] ang, output longint c, output longint s);
            logic [31:0] t;
            logic [31:0] a;
            logic flip;
            longint x, y, z, xs, ys;
            t = ang + QUARTER_TURN;
            flip = t[31];
            a = flip ? ang + HALF_TURN : ang;
            x = 652032874;
            y = 0;
            z = longint'($signed(a));
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys; y = y + xs; z = z - ARC_TAB[i];
                end
                else
                begin
                    x = x + ys; y = y - xs; z = z + ARC_TAB[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint bearing(input longint x, input longint y);
            longint z, t, xs, ys;
            z = 0;
            if (x < 0)
            begin
                t = x; x = y; y = -t; z = 64'd1073741824;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys; y = y - xs; z = z + ARC_TAB[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - ARC_TAB[i];
                end
            end
            return z;
        endfunction

        function logic [31:0] central(input logic [31:0] la, input logic [31:0] pa,
                                      input logic [31:0] lb, input logic [31:0] pb);
            longint ca, sa, cb, sb, cd, sd, f, d, res, x1, y1, cx, cy, cz, fc;
            logic [63:0] len, u, fa;
            rotate(pa, ca, sa);
            rotate(pb, cb, sb);
            rotate(la - lb, cd, sd);
            f = qm(sa, sb) + qm(qm(ca, cb), cd);
            if (f > 64'sd2147483647)
                f = 64'sd2147483647;
            if (f < -64'sd2147483648)
                f = -64'sd2147483648;
            d = f - 64'sd1073741824;
            if (d < 0)
                d = -d;
            if (d <= longint'(unity_tol))
            begin
                x1 = qm(cd, ca);
                y1 = qm(sd, ca);
                cx = qm(y1, sb);
                cy = qm(sa, cb) - qm(x1, sb);
                cz = -qm(y1, cb);
                len = root64(sq_sat(cx) + sq_sat(cy) + sq_sat(cz));
                u = (len * 64'd2734261102) >> 32;
                if (u > 64'h8000_0000)
                    u = 64'h8000_0000;
                res = longint'(u);
            end
            else
            begin
                fc = f;
                if (fc > 64'sd1073741824)
                    fc = 64'sd1073741824;
                if (fc < -64'sd1073741824)
                    fc = -64'sd1073741824;
                fa = (fc < 0) ? 64'(-fc) : 64'(fc);
                res = bearing(fc, longint'(root64(ONE_Q60 - fa * fa)));
                if (res < 0)
                    res = 0;
                if (res > 64'sd2147483648)
                    res = 64'sd2147483648;
            end
            if (res <= longint'(zero_tol))
                res = 0;
            return res[31:0];
        endfunction

        function void note_pair(input logic [31:0] la, input logic [31:0] pa,
                                input logic [31:0] lb, input logic [31:0] pb);
            pending_angles.push_back(central(la, pa, lb, pb));
        endfunction

        function void check_angle(input logic [31:0] got);
            logic [31:0] want;
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected central_angle %0d", $time, got);
                errors++;
                return;
            end
            want = pending_angles.pop_front();
            if (got !== want)
            begin
                $display("%0t: central_angle expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] lng_a = '0;
    logic signed [31:0] lat_a = '0;
    logic [31:0] lng_b = '0;
    logic signed [31:0] lat_b = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] central_angle;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_UNITY_TOL;
    logic [15:0] cfg_data = '0;

    angle_board board = new();
    bit calm = 1'b1;
    bit squeeze = 1'b0;
    int quiet_cycles = 0;

    great_circle_distance_core #(.CORDIC_STEPS(STEPS)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_pair(lng_a, lat_a, lng_b, lat_b);
        if (rst_n && out_valid && !out_stall)
            board.check_angle(central_angle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** great_circle_distance_core: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        int run;
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                out_stall = 1'b1;
                repeat (400) @(negedge clk);
                squeeze = 1'b0;
                out_stall = 1'b0;
            end
            else if (calm)
                out_stall = 1'b0;
            else
            begin
                run = pick_gap();
                if (run > 0)
                begin
                    out_stall = 1'b1;
                    repeat (run - 1) @(negedge clk);
                end
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_pair(input logic [31:0] la, input logic [31:0] pa,
                             input logic [31:0] lb, input logic [31:0] pb);
        int g;
        @(negedge clk);
        in_valid = 1'b1;
        lng_a = la;
        lat_a = pa;
        lng_b = lb;
        lat_b = pb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        g = calm ? 0 : pick_gap();
        if (g > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_UNITY_TOL)
            board.unity_tol = val;
        else
            board.zero_tol = val;
    endtask

    task automatic random_pair();
        logic [31:0] la, pa, lb, pb;
        int kind;
        kind = $urandom_range(0, 9);
        la = $urandom();
        lb = $urandom();
        pa = 32'($urandom_range(0, 32'h8000_0000)) - QUARTER_TURN;
        pb = 32'($urandom_range(0, 32'h8000_0000)) - QUARTER_TURN;
        case (kind)
            0, 1:
            begin
                pa = $urandom();
                pb = $urandom();
            end
            2, 3, 4:
            begin
                lb = la + 32'($urandom_range(0, 4000)) - 32'd2000;
                pb = pa + 32'($urandom_range(0, 4000)) - 32'd2000;
            end
            5:
            begin
                lb = la + HALF_TURN + 32'($urandom_range(0, 4000)) - 32'd2000;
                pb = -pa + 32'($urandom_range(0, 4000)) - 32'd2000;
            end
            6:
            begin
                lb = la;
                pb = pa;
            end
            default: ;
        endcase
        send_pair(la, pa, lb, pb);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        calm = 1'b1;
        send_pair(32'd0, 32'd0, 32'd0, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'h4000_0000, 32'd0, 32'hC000_0000);
        send_pair(32'd0, 32'h4000_0000, 32'h1234_5678, 32'h4000_0000);
        send_pair(32'd0, 32'hC000_0000, 32'hFFFF_FFFF, 32'hC000_0000);
        send_pair(32'd0, 32'd0, HALF_TURN, 32'd0);
        send_pair(32'h4000_0000, 32'h2000_0000, 32'hC000_0000, 32'hE000_0000);
        send_pair(32'd5, 32'd0, 32'hFFFF_FFFB, 32'd0);
        send_pair(32'd100, 32'h1000_0000, 32'd101, 32'h1000_0001);
        send_pair(32'd0, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
        send_pair(32'd0, 32'd0, 32'h4000_0000, 32'd0);
        send_pair(32'h8000_0000, 32'h3FFF_FFFF, 32'h8000_0001, 32'h3FFF_FFFF);
        send_pair(32'd0, 32'd0, 32'd1, 32'd0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_UNITY_TOL, 16'd1);
                    write_reg(CFG_ZERO_TOL, 16'd1);
                end
                1:
                begin
                    write_reg(CFG_UNITY_TOL, 16'hFFFF);
                    write_reg(CFG_ZERO_TOL, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_UNITY_TOL, 16'd0);
                    write_reg(CFG_ZERO_TOL, 16'd0);
                end
                default:
                begin
                    write_reg(CFG_UNITY_TOL, 16'($urandom()));
                    write_reg(CFG_ZERO_TOL, 16'($urandom()));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                calm = (n < 50);
                if (phase == 1 && n == 100)
                    squeeze = 1'b1;
                random_pair();
            end
            calm = 1'b1;
            drain();
        end

        if (board.pending_angles.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.pending_angles.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("** great_circle_distance_core: PASSED **");
        else
            $display("** great_circle_distance_core: FAILED **");
        $finish;
    end
endmodule
